### src/gbf_pkg.sv
// Shared types and constants for the glyph bitmap finisher.
// Used by glyph_bitmap_finisher; depends on nothing else.
package gbf_pkg;

  // Width of pixel counters and store addresses (image is at most 511 x 127)
  localparam int CNT_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef enum logic [7:0] {
    REG_IMAGE_WIDTH  = 8'd0,
    REG_IMAGE_HEIGHT = 8'd1,
    REG_CROP_ENABLE  = 8'd2,
    REG_COLOR_FONT   = 8'd3
  } reg_index_t;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

endpackage

### src/glyph_bitmap_finisher.sv
// Glyph bitmap finisher: pixel store, bounding box tracking, unpremultiply.
// Depends on gbf_pkg.
//
// Usage:
//   Input stream (s_*): tuser is the item kind. Kind load writes one
//   premultiplied RGBA pixel in raster order into the pixel store and
//   updates the bounding box of covered pixels. Kind fetch returns one
//   output pixel on the m_* stream once the image is fully loaded; a fetch
//   before that is dropped without a result, and so is a load after it.
//   Configuration (cfg_*) sets image size, cropping and the color-font flag;
//   writing a size restarts the image. Write it only while the block idles.
// Sequencing:
//   Items are taken only in the idle state, so a fetch holds the input. A
//   fetch runs through an address multiply, one synchronous store read and,
//   for color output, an 8-step restoring divide shared by the three channels
//   in lockstep; coverage pixels skip the divide, uncovered images all three.
// Reset: control state clears, registers return to their reset values and
//   the image restarts. Store contents stay undefined until loaded.
// Stall: a finished result waits in the output register; the next input
//   is still taken, and a second result waits in the done state until the
//   receiver takes the first.
module glyph_bitmap_finisher #(
  parameter int MAX_WIDTH   = 256,
  parameter int MAX_HEIGHT  = 64,
  parameter int STORE_DEPTH = 16384
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  input  logic        s_tuser,   // kind
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24],
  // crop_left[39:32], crop_top[45:40], out_width[54:46], out_height[61:55], zeros
  output logic [63:0] m_tdata,
  output logic        m_tlast,   // last_pixel
  output logic [1:0]  m_tuser,   // is_rgba[0], no_coverage[1]
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  localparam int SW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = gbf_pkg::CNT_W;

  // configuration
  logic [8:0] image_width;
  logic [6:0] image_height;
  logic       crop_enable;
  logic       color_font;

  // image state
  logic [CW-1:0] load_count;
  logic [8:0]    load_col;
  logic [6:0]    load_row;
  logic [8:0]    fetch_col;
  logic [6:0]    fetch_row;
  logic [8:0]    min_column, max_column;
  logic [6:0]    min_row, max_row;
  logic          covered;
  logic          color_seen;

  // pixel store
  logic [31:0]   pixel_store [STORE_DEPTH];
  logic [31:0]   rd_data;
  logic          st_we;
  logic [SW-1:0] st_waddr;
  logic [SW-1:0] st_raddr;

  // fetch datapath
  gbf_pkg::state_t state, state_next;
  logic [6:0]    src_row;
  logic [8:0]    src_col;
  logic [CW-1:0] row_base;
  logic [CW-1:0] rd_addr;
  logic          in_range;
  logic          rgba;
  logic          alpha_zero;
  logic [2:0]    div_cnt;
  logic [15:0]   rem_r, rem_g, rem_b;
  logic [15:0]   den;
  logic [7:0]    quo_r, quo_g, quo_b;
  logic          ovf_r, ovf_g, ovf_b;
  logic [7:0]    pix_a;

  // result under construction and output register
  logic [7:0] res_r, res_g, res_b, res_a;
  logic       res_last, res_rgba, res_nocov;
  logic [7:0] res_left;
  logic [5:0] res_top;
  logic [8:0] res_ow;
  logic [6:0] res_oh;

  // derived
  logic [8:0]    used_w;
  logic [6:0]    used_h;
  logic [CW-1:0] total;
  logic          full;
  logic [8:0]    crop_l;
  logic [6:0]    crop_t;
  logic [8:0]    crop_w;
  logic [6:0]    crop_h;
  logic          fetch_last;
  logic          restart;
  logic          accept;
  logic          out_load;
  logic [31:0]   px;
  logic [7:0]    lo, hi;
  logic [7:0]    in_r, in_g, in_b, in_a;

  assign in_r = s_tdata[7:0];
  assign in_g = s_tdata[15:8];
  assign in_b = s_tdata[23:16];
  assign in_a = s_tdata[31:24];

  assign used_w = (image_width == 9'd0) ? 9'd1 :
                  (32'(image_width) > MAX_WIDTH) ? 9'(MAX_WIDTH) : image_width;
  assign used_h = (image_height == 7'd0) ? 7'd1 :
                  (32'(image_height) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : image_height;
  assign total  = CW'(used_w) * CW'(used_h);
  assign full   = (load_count >= total);

  assign crop_l = crop_enable ? min_column : 9'd0;
  assign crop_t = crop_enable ? min_row : 7'd0;
  assign crop_w = crop_enable ? 9'(max_column - min_column + 9'd1) : used_w;
  assign crop_h = crop_enable ? 7'(max_row - min_row + 7'd1) : used_h;
  assign fetch_last = (fetch_col == crop_w - 9'd1) && (fetch_row == crop_h - 7'd1);

  assign s_tready  = (state == gbf_pkg::ST_IDLE);
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == gbf_pkg::ST_DONE) && (!m_tvalid || m_tready);

  // restart the image on the last emitted pixel (decided at fetch accept)
  assign restart = accept && (s_tuser == gbf_pkg::KIND_FETCH) && full &&
                   (!covered || fetch_last);

  // store write on an in-range load
  assign st_we    = accept && (s_tuser == gbf_pkg::KIND_LOAD) && !full &&
                    (32'(load_count) < STORE_DEPTH);
  assign st_waddr = SW'(load_count);
  assign rd_addr  = row_base + CW'(src_col);
  assign st_raddr = SW'(rd_addr);

  always_ff @(posedge clk) begin
    if (st_we) begin
      pixel_store[st_waddr] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= pixel_store[st_raddr];
  end

  assign px = in_range ? rd_data : 32'd0;

  always_comb begin
    lo = (in_r < in_g) ? in_r : in_g;
    lo = (lo < in_b) ? lo : in_b;
    hi = (in_r > in_g) ? in_r : in_g;
    hi = (hi > in_b) ? hi : in_b;
  end

  // next-state logic
  always_comb begin
    state_next = state;
    unique case (state)
      gbf_pkg::ST_IDLE: begin
        if (accept && (s_tuser == gbf_pkg::KIND_FETCH) && full) begin
          state_next = covered ? gbf_pkg::ST_MUL : gbf_pkg::ST_DONE;
        end
      end
      gbf_pkg::ST_MUL:  state_next = gbf_pkg::ST_ADDR;
      gbf_pkg::ST_ADDR: state_next = gbf_pkg::ST_PREP;
      gbf_pkg::ST_PREP: state_next = rgba ? gbf_pkg::ST_DIV : gbf_pkg::ST_DONE;
      gbf_pkg::ST_DIV: begin
        if (div_cnt == 3'd0) begin
          state_next = gbf_pkg::ST_DONE;
        end
      end
      gbf_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = gbf_pkg::ST_IDLE;
        end
      end
      default: state_next = gbf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // configuration and image control state
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 9'd1;
      image_height <= 7'd1;
      crop_enable  <= 1'b0;
      color_font   <= 1'b0;
      load_count   <= '0;
      load_col     <= '0;
      load_row     <= '0;
      fetch_col    <= '0;
      fetch_row    <= '0;
      covered      <= 1'b0;
      color_seen   <= 1'b0;
    end else begin
      if (accept && (s_tuser == gbf_pkg::KIND_LOAD) && !full) begin
        load_count <= load_count + CW'(1);
        if (load_col == used_w - 9'd1) begin
          load_col <= '0;
          load_row <= load_row + 7'd1;
        end else begin
          load_col <= load_col + 9'd1;
        end
        if (in_a != 8'd0) begin
          covered <= 1'b1;
          // compare one bit wider so a bright gray does not wrap
          if ({1'b0, hi} > {1'b0, lo} + 9'd4) begin
            color_seen <= 1'b1;
          end
        end
      end
      if (accept && (s_tuser == gbf_pkg::KIND_FETCH) && full && covered && !fetch_last) begin
        if (fetch_col == crop_w - 9'd1) begin
          fetch_col <= '0;
          fetch_row <= fetch_row + 7'd1;
        end else begin
          fetch_col <= fetch_col + 9'd1;
        end
      end
      if (restart) begin
        load_count <= '0;
        load_col   <= '0;
        load_row   <= '0;
        fetch_col  <= '0;
        fetch_row  <= '0;
        covered    <= 1'b0;
        color_seen <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          gbf_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          gbf_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[6:0];
          gbf_pkg::REG_CROP_ENABLE:  crop_enable  <= cfg_data[0];
          gbf_pkg::REG_COLOR_FONT:   color_font   <= cfg_data[0];
          default: ;
        endcase
        if (cfg_index == gbf_pkg::REG_IMAGE_WIDTH ||
            cfg_index == gbf_pkg::REG_IMAGE_HEIGHT) begin
          load_count <= '0;
          load_col   <= '0;
          load_row   <= '0;
          fetch_col  <= '0;
          fetch_row  <= '0;
          covered    <= 1'b0;
          color_seen <= 1'b0;
        end
      end
    end
  end

  // bounding box: first covered pixel seeds it
  always_ff @(posedge clk) begin
    if (accept && (s_tuser == gbf_pkg::KIND_LOAD) && !full && in_a != 8'd0) begin
      if (!covered || load_col < min_column) min_column <= load_col;
      if (!covered || load_col > max_column) max_column <= load_col;
      if (!covered || load_row < min_row)    min_row    <= load_row;
      if (!covered || load_row > max_row)    max_row    <= load_row;
    end
  end

  // fetch datapath: address, read, divide
  always_ff @(posedge clk) begin
    unique case (state)
      gbf_pkg::ST_IDLE: begin
        if (accept && (s_tuser == gbf_pkg::KIND_FETCH) && full) begin
          src_row   <= crop_t + fetch_row;
          src_col   <= crop_l + fetch_col;
          rgba      <= color_font && color_seen;
          res_last  <= !covered || fetch_last;
          res_rgba  <= covered && color_font && color_seen;
          res_nocov <= !covered;
          res_left  <= covered ? crop_l[7:0] : 8'd0;
          res_top   <= covered ? crop_t[5:0] : 6'd0;
          res_ow    <= covered ? crop_w : 9'd0;
          res_oh    <= covered ? crop_h : 7'd0;
          res_r     <= 8'd0;
          res_g     <= 8'd0;
          res_b     <= 8'd0;
          res_a     <= 8'd0;
        end
      end
      gbf_pkg::ST_MUL: begin
        row_base <= CW'(src_row) * CW'(used_w);
      end
      gbf_pkg::ST_ADDR: begin
        in_range <= (32'(rd_addr) < STORE_DEPTH);
      end
      gbf_pkg::ST_PREP: begin
        pix_a      <= px[31:24];
        alpha_zero <= (px[31:24] == 8'd0);
        rem_r      <= {px[7:0], 8'd0} - 16'(px[7:0]) + 16'(px[31:25]);
        rem_g      <= {px[15:8], 8'd0} - 16'(px[15:8]) + 16'(px[31:25]);
        rem_b      <= {px[23:16], 8'd0} - 16'(px[23:16]) + 16'(px[31:25]);
        den        <= {1'b0, px[31:24], 7'd0};
        // quotient of 256 or more saturates
        ovf_r      <= px[7:0] >= px[31:24];
        ovf_g      <= px[15:8] >= px[31:24];
        ovf_b      <= px[23:16] >= px[31:24];
        div_cnt    <= 3'd7;
        if (!rgba) begin
          res_r <= 8'd255;
          res_g <= 8'd255;
          res_b <= 8'd255;
          res_a <= (px[31:24] > px[7:0] ? px[31:24] : px[7:0]) >
                   (px[15:8] > px[23:16] ? px[15:8] : px[23:16]) ?
                   (px[31:24] > px[7:0] ? px[31:24] : px[7:0]) :
                   (px[15:8] > px[23:16] ? px[15:8] : px[23:16]);
        end
      end
      gbf_pkg::ST_DIV: begin
        quo_r <= {quo_r[6:0], rem_r >= den};
        quo_g <= {quo_g[6:0], rem_g >= den};
        quo_b <= {quo_b[6:0], rem_b >= den};
        if (rem_r >= den) rem_r <= rem_r - den;
        if (rem_g >= den) rem_g <= rem_g - den;
        if (rem_b >= den) rem_b <= rem_b - den;
        den     <= den >> 1;
        div_cnt <= div_cnt - 3'd1;
      end
      gbf_pkg::ST_DONE: begin
        if (rgba && !res_nocov) begin
          res_r <= alpha_zero ? 8'd0 : (ovf_r ? 8'd255 : quo_r);
          res_g <= alpha_zero ? 8'd0 : (ovf_g ? 8'd255 : quo_g);
          res_b <= alpha_zero ? 8'd0 : (ovf_b ? 8'd255 : quo_b);
          res_a <= pix_a;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // in the done state the unpremultiplied channels are settled through next values
  logic [7:0] fin_r, fin_g, fin_b, fin_a;
  assign fin_r = (rgba && !res_nocov) ? (alpha_zero ? 8'd0 : (ovf_r ? 8'd255 : quo_r)) : res_r;
  assign fin_g = (rgba && !res_nocov) ? (alpha_zero ? 8'd0 : (ovf_g ? 8'd255 : quo_g)) : res_g;
  assign fin_b = (rgba && !res_nocov) ? (alpha_zero ? 8'd0 : (ovf_b ? 8'd255 : quo_b)) : res_b;
  assign fin_a = (rgba && !res_nocov) ? pix_a : res_a;

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, res_oh, res_ow, res_top, res_left, fin_a, fin_b, fin_g, fin_r};
      m_tlast <= res_last;
      m_tuser <= {res_nocov, res_rgba};
    end
  end

`ifndef ASSERT_OFF
  a_nocov_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |-> m_tlast)
    else $error("no-coverage result without last_pixel");

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= total)
    else $error("load count beyond image size");

  a_mask_white: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[1] && !m_tuser[0]) |-> (m_tdata[23:0] == 24'hFFFFFF))
    else $error("coverage result not white");

  a_fetch_full: assert property (@(posedge clk) disable iff (rst)
    (state == gbf_pkg::ST_IDLE && accept && s_tuser == gbf_pkg::KIND_FETCH && !full)
    |=> state == gbf_pkg::ST_IDLE)
    else $error("early fetch started work");
`endif

endmodule
